// ===== hw/rtl/tgad_pkg.sv =====
package tgad_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXELS = 3'd2,
    PH_DONE   = 3'd3,
    PH_REJECT = 3'd4
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_COLOR_MAP = 2'd1;
  localparam logic [1:0] ERR_IMG_TYPE  = 2'd2;
  localparam logic [1:0] ERR_DEPTH     = 2'd3;

  // Header byte offsets
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] DEPTH_15           = 8'd15;
  localparam logic [7:0] ALPHA_OPAQUE       = 8'hFF;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic        truncated;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] pixel_row;
    logic [15:0] pixel_column;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [7:0]  chan3;
    logic        last_pixel;
  } out_item_t;

  // Bytes per pixel for a depth, zero when unsupported
  function automatic logic [2:0] bytes_per_pixel(input logic [7:0] depth);
    logic [2:0] bpp;
    case (depth)
      8'd15, 8'd16: bpp = 3'd2;
      8'd24:        bpp = 3'd3;
      8'd32:        bpp = 3'd4;
      default:      bpp = 3'd0;
    endcase
    return bpp;
  endfunction

endpackage

// ===== hw/rtl/tgad_core.sv =====
module tgad_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  tgad_pkg::in_item_t  item,
  output logic                have,
  output tgad_pkg::out_item_t res
);
  import tgad_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic        map_nz_r, map_nz_nxt;
  logic        type_ok_r, type_ok_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [23:0] pix_r, pix_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;

  logic [7:0]  b;
  logic [2:0]  bpp;
  logic        more;
  logic [15:0] col_inc;
  logic        last_row;
  logic        last_col;

  assign b        = item.file_byte;
  assign bpp      = bytes_per_pixel(depth_r);
  assign col_inc  = col_r + 16'd1;
  assign last_row = ({1'b0, row_r} + 17'd1) == {1'b0, height_r};
  assign last_col = ({1'b0, col_r} + 17'd1) == {1'b0, width_r};

  // Decode one byte against the current phase
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    id_left_nxt = id_left_r;
    map_nz_nxt  = map_nz_r;
    type_ok_nxt = type_ok_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    depth_nxt   = depth_r;
    pix_nxt     = pix_r;
    bip_nxt     = bip_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    have        = 1'b0;
    more        = 1'b0;
    res         = '0;

    unique case (phase_r)
      PH_HEADER: begin
        hdr_cnt_nxt = hdr_cnt_r + 5'd1;
        case (hdr_cnt_r)
          HDR_ID_LEN:    id_left_nxt = b;
          HDR_MAP_TYPE:  map_nz_nxt  = (b != 8'd0);
          HDR_IMG_TYPE:  type_ok_nxt = (b == IMG_TYPE_TRUECOLOR);
          HDR_WIDTH_LO:  width_nxt[7:0]   = b;
          HDR_WIDTH_HI:  width_nxt[15:8]  = b;
          HDR_HEIGHT_LO: height_nxt[7:0]  = b;
          HDR_HEIGHT_HI: height_nxt[15:8] = b;
          HDR_DEPTH:     depth_nxt = b;
          default: ;
        endcase
        if (hdr_cnt_r < HDR_LAST) begin
          more = 1'b1;
        end else begin
          have = 1'b1;
          if (map_nz_r) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_COLOR_MAP;
            phase_nxt      = PH_REJECT;
          end else if (!type_ok_r) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_IMG_TYPE;
            phase_nxt      = PH_REJECT;
          end else if (bpp == 3'd0) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_DEPTH;
            phase_nxt      = PH_REJECT;
          end else begin
            res.kind = KIND_HEADER;
            if (width_r == 16'd0 || height_r == 16'd0) begin
              res.last_pixel = 1'b1;
              phase_nxt      = PH_DONE;
            end else begin
              more      = 1'b1;
              phase_nxt = (id_left_r != 8'd0) ? PH_SKIP : PH_PIXELS;
            end
          end
        end
      end
      PH_SKIP: begin
        // drop image ID bytes
        id_left_nxt = id_left_r - 8'd1;
        if (id_left_r == 8'd1) begin
          phase_nxt = PH_PIXELS;
        end
        more = 1'b1;
      end
      PH_PIXELS: begin
        if (({1'b0, bip_r} + 3'd1) < bpp) begin
          // gather a byte of the pixel
          case (bip_r)
            2'd0:    pix_nxt[7:0]   = pix_r[7:0]   | b;
            2'd1:    pix_nxt[15:8]  = pix_r[15:8]  | b;
            default: pix_nxt[23:16] = pix_r[23:16] | b;
          endcase
          bip_nxt = bip_r + 2'd1;
          more    = 1'b1;
        end else begin
          if (bpp == 3'd2) begin
            res.chan0 = {3'b000, b[6:2]};
            res.chan1 = {3'b000, b[1:0], pix_r[7:5]};
            res.chan2 = {3'b000, pix_r[4:0]};
            res.chan3 = (depth_r == DEPTH_15 || b[7]) ? ALPHA_OPAQUE : 8'd0;
          end else begin
            res.chan0 = pix_r[7:0];
            res.chan1 = pix_r[15:8];
            res.chan2 = pix_r[23:16];
            res.chan3 = (bpp == 3'd4) ? b : ALPHA_OPAQUE;
          end
          have             = 1'b1;
          res.kind         = KIND_PIXEL;
          res.pixel_row    = row_r;
          res.pixel_column = col_r;
          pix_nxt          = '0;
          bip_nxt          = 2'd0;
          if (last_row && last_col) begin
            res.last_pixel = 1'b1;
            phase_nxt      = PH_DONE;
          end else begin
            more = 1'b1;
            if (col_inc >= width_r) begin
              col_nxt = 16'd0;
              row_nxt = row_r + 16'd1;
            end else begin
              col_nxt = col_inc;
            end
          end
        end
      end
      PH_DONE, PH_REJECT: ;
      default: ;
    endcase

    res.image_width  = width_nxt;
    res.image_height = height_nxt;

    // Flag an early end of file
    if (item.end_of_file && more) begin
      res.truncated = 1'b1;
      if (!have) begin
        have           = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_NONE;
      end
    end

    // Rearm for the next file
    if (item.end_of_file) begin
      phase_nxt   = PH_HEADER;
      hdr_cnt_nxt = '0;
      id_left_nxt = '0;
      map_nz_nxt  = 1'b0;
      type_ok_nxt = 1'b0;
      width_nxt   = '0;
      height_nxt  = '0;
      depth_nxt   = '0;
      pix_nxt     = '0;
      bip_nxt     = '0;
      row_nxt     = '0;
      col_nxt     = '0;
    end
  end

  // Advance the decoder state on each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      id_left_r <= '0;
      map_nz_r  <= 1'b0;
      type_ok_r <= 1'b0;
      width_r   <= '0;
      height_r  <= '0;
      depth_r   <= '0;
      pix_r     <= '0;
      bip_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      id_left_r <= id_left_nxt;
      map_nz_r  <= map_nz_nxt;
      type_ok_r <= type_ok_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      depth_r   <= depth_nxt;
      pix_r     <= pix_nxt;
      bip_r     <= bip_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

// ===== hw/rtl/tga_truecolor_pixel_decoder_unit.sv =====
// A byte accepted into the input register is decoded when it fires, and its item is loaded into the result register.
// Throughput: 1 byte per cycle while out_stall is low; the input register and the result register
// overlap, so one more byte is taken while a result waits on out_stall.
// Reset (rst_n low, synchronous): both registers empty, decoder back to the
// header phase with all counters and header fields cleared.
module tga_truecolor_pixel_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tgad_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tgad_pkg::out_item_t out_item
);
  import tgad_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;

  logic      fire;
  logic      in_acc;
  logic      have;
  out_item_t res;

  // Decode when the result register is free or draining
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  // Hold the incoming item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_item;
    end
  end

  tgad_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .have  (have),
    .res   (res)
  );

  // Load a result or drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && have) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && have) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/tgad_checker.sv =====
module tgad_sva (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tgad_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input tgad_pkg::out_item_t out_item
);
  import tgad_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  // Pixels carry no error code
  a_pixel_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_PIXEL |-> out_item.error_code == ERR_NONE)
    else $error("pixel item with error code");

  // A bare error item is always a truncation
  a_err_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_ERROR && out_item.error_code == ERR_NONE
      |-> out_item.truncated)
    else $error("error item without cause");

  // Non-pixel items carry no position or alpha
  a_nonpix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind != KIND_PIXEL
      |-> out_item.pixel_row == 16'd0 && out_item.pixel_column == 16'd0 &&
          out_item.chan3 == 8'd0)
    else $error("non-pixel item with pixel data");

endmodule

bind tga_truecolor_pixel_decoder_unit tgad_sva u_tgad_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== test/tgad_checker.sv =====
`timescale 1ns / 100ps

module tgad_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tgad_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tgad_pkg::out_item_t out_item,
  output int                  mismatch_count,
  output int                  outstanding
);
  import tgad_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Decoder state, kept apart from the block
  phase_t      ph;
  logic [4:0]  hdr_idx;
  logic [7:0]  skip_left;
  logic [7:0]  img_type;
  logic [7:0]  map_type;
  logic [7:0]  depth;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [23:0] partial;
  logic [1:0]  byte_idx;
  logic [15:0] row;
  logic [15:0] col;

  // Decoded items still to come out of the block, oldest first
  out_item_t decoded_q[$];

  function automatic int depth_to_bytes(input logic [7:0] d);
    if (d == 8'd15 || d == 8'd16) return 2;
    if (d == 8'd24) return 3;
    if (d == 8'd32) return 4;
    return 0;
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf({"kind %0d err %0d trunc %0d size %0dx%0d pos r%0d c%0d ",
                      "ch %02h %02h %02h %02h last %0d"},
                     r.kind, r.error_code, r.truncated, r.image_width, r.image_height,
                     r.pixel_row, r.pixel_column, r.chan0, r.chan1, r.chan2, r.chan3,
                     r.last_pixel);
  endfunction

  task automatic clear_state();
    ph        = PH_HEADER;
    hdr_idx   = '0;
    skip_left = '0;
    img_type  = '0;
    map_type  = '0;
    depth     = '0;
    img_w     = '0;
    img_h     = '0;
    partial   = '0;
    byte_idx  = '0;
    row       = '0;
    col       = '0;
  endtask

  // Work out what one file byte yields and queue it
  task automatic decode_byte(input in_item_t it);
    out_item_t   r;
    logic [7:0]  b;
    logic        have;
    logic        more;
    int          bpp;
    logic [15:0] word;
    r    = '0;
    b    = it.file_byte;
    have = 1'b0;
    more = 1'b0;
    case (ph)
      PH_HEADER: begin
        case (hdr_idx)
          HDR_ID_LEN:    skip_left = b;
          HDR_MAP_TYPE:  map_type = b;
          HDR_IMG_TYPE:  img_type = b;
          HDR_WIDTH_LO:  img_w[7:0] = b;
          HDR_WIDTH_HI:  img_w[15:8] = b;
          HDR_HEIGHT_LO: img_h[7:0] = b;
          HDR_HEIGHT_HI: img_h[15:8] = b;
          HDR_DEPTH:     depth = b;
          default: ;
        endcase
        if (hdr_idx < HDR_LAST) begin
          hdr_idx = hdr_idx + 5'd1;
          more = 1'b1;
        end else begin
          hdr_idx = hdr_idx + 5'd1;
          // Colour map wins over image type, which wins over depth
          if (map_type != 8'd0) r.error_code = ERR_COLOR_MAP;
          else if (img_type != IMG_TYPE_TRUECOLOR) r.error_code = ERR_IMG_TYPE;
          else if (depth_to_bytes(depth) == 0) r.error_code = ERR_DEPTH;
          have = 1'b1;
          if (r.error_code != ERR_NONE) begin
            r.kind = KIND_ERROR;
            ph = PH_REJECT;
          end else begin
            r.kind = KIND_HEADER;
            if (img_w == 16'd0 || img_h == 16'd0) begin
              r.last_pixel = 1'b1;
              ph = PH_DONE;
            end else begin
              more = 1'b1;
              ph = (skip_left != 8'd0) ? PH_SKIP : PH_PIXELS;
            end
          end
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) ph = PH_PIXELS;
        more = 1'b1;
      end
      PH_PIXELS: begin
        bpp = depth_to_bytes(depth);
        if (int'(byte_idx) + 1 < bpp) begin
          partial = partial | (24'(b) << (8 * byte_idx));
          byte_idx = byte_idx + 2'd1;
          more = 1'b1;
        end else begin
          if (bpp == 2) begin
            // 5-bit channels stay unwidened
            word = {b, partial[7:0]};
            r.chan0 = {3'b000, word[14:10]};
            r.chan1 = {3'b000, word[9:5]};
            r.chan2 = {3'b000, word[4:0]};
            if (depth == DEPTH_15 || word[15]) r.chan3 = ALPHA_OPAQUE;
            else r.chan3 = 8'h00;
          end else begin
            r.chan0 = partial[7:0];
            r.chan1 = partial[15:8];
            r.chan2 = partial[23:16];
            r.chan3 = (bpp == 4) ? b : ALPHA_OPAQUE;
          end
          have = 1'b1;
          r.kind = KIND_PIXEL;
          r.pixel_row = row;
          r.pixel_column = col;
          partial = '0;
          byte_idx = '0;
          if (17'(row) + 17'd1 == 17'(img_h) && 17'(col) + 17'd1 == 17'(img_w)) begin
            r.last_pixel = 1'b1;
            ph = PH_DONE;
          end else begin
            more = 1'b1;
            col = col + 16'd1;
            if (col >= img_w) begin
              col = '0;
              row = row + 16'd1;
            end
          end
        end
      end
      default: ;
    endcase

    // Early end of file marks the item, or makes one of its own
    if (it.end_of_file && more) begin
      r.truncated = 1'b1;
      if (!have) begin
        have = 1'b1;
        r.kind = KIND_ERROR;
        r.error_code = ERR_NONE;
      end
    end
    if (have) begin
      r.image_width = img_w;
      r.image_height = img_h;
      decoded_q.push_back(r);
    end
    if (it.end_of_file) clear_state();
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("[%0t] unexpected item: %s", $time, describe(got));
    end else begin
      want = decoded_q.pop_front();
      if (got.kind !== want.kind || got.error_code !== want.error_code ||
          got.truncated !== want.truncated || got.image_width !== want.image_width ||
          got.image_height !== want.image_height || got.pixel_row !== want.pixel_row ||
          got.pixel_column !== want.pixel_column || got.chan0 !== want.chan0 ||
          got.chan1 !== want.chan1 || got.chan2 !== want.chan2 ||
          got.chan3 !== want.chan3 || got.last_pixel !== want.last_pixel) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("[%0t] mismatch, expected: %s", $time, describe(want));
          $display("[%0t]           actual:   %s", $time, describe(got));
        end
      end
    end
  endtask

  // Check leaving items first, then decode the arriving byte
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      decoded_q.delete();
      mismatch_count = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (in_valid && !in_stall) decode_byte(in_item);
      outstanding <= decoded_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tgad_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 8;
  localparam int ITEM_TARGET     = 1200;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 16;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int mismatch_count;
  int outstanding;
  int idle_cycles;
  int items_sent;
  int burst_left;
  bit hold_off_req;
  bit hold_off_done;

  logic [7:0] file_bytes[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  tga_truecolor_pixel_decoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  tgad_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall patterns of varying density, one long hold-off on request
  initial begin
    int mode;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 150)) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Bias towards all-zero and all-one bytes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte in bursts with random gaps, hold until taken
  task automatic offer_byte(input logic [7:0] b, input logic eof);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 300 : 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.file_byte = b;
    it.end_of_file = eof;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Lay out a file: header, ID bytes, pixel data, trailing bytes; cut > 0 truncates
  task automatic build_file(input int id_len, input int map_type, input int img_type,
                            input int w, input int h, input int depth,
                            input int cut, input int trail);
    longint body;
    file_bytes.delete();
    file_bytes.push_back(8'(id_len));
    file_bytes.push_back(8'(map_type));
    file_bytes.push_back(8'(img_type));
    repeat (9) file_bytes.push_back(rand_byte());
    file_bytes.push_back(8'(w));
    file_bytes.push_back(8'(w >> 8));
    file_bytes.push_back(8'(h));
    file_bytes.push_back(8'(h >> 8));
    file_bytes.push_back(8'(depth));
    file_bytes.push_back(rand_byte());
    repeat (id_len) file_bytes.push_back(rand_byte());
    body = longint'(w) * longint'(h) * longint'((depth + 7) / 8) + trail;
    if (cut > 0 && body > cut) body = cut;
    repeat (body) file_bytes.push_back(rand_byte());
    if (cut > 0) while (file_bytes.size() > cut) void'(file_bytes.pop_back());
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      offer_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Stop offering until every decoded item has left the block
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_file(input int id_len, input int map_type, input int img_type,
                          input int w, input int h, input int depth,
                          input int cut, input int trail);
    build_file(id_len, map_type, img_type, w, h, depth, cut, trail);
    send_file();
  endtask

  initial begin
    int sel;
    int w;
    int h;
    int depth;
    int idl;
    int total;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    items_sent = 0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Well-formed images of every depth
    run_file(0, 0, 2, 2, 2, 24, 0, 0);
    run_file(3, 0, 2, 3, 1, 32, 0, 0);
    run_file(0, 0, 2, 2, 1, 15, 0, 0);
    run_file(1, 0, 2, 2, 2, 16, 0, 0);
    run_file(255, 0, 2, 1, 1, 16, 0, 0);
    // Rejections in priority order, later bytes ignored
    run_file(0, 1, 3, 2, 2, 8, 0, 0);
    run_file(0, 255, 2, 2, 2, 24, 0, 0);
    run_file(0, 0, 3, 2, 2, 8, 0, 0);
    run_file(0, 0, 255, 1, 1, 24, 0, 0);
    run_file(0, 0, 2, 2, 2, 8, 0, 2);
    // Empty images, ID and trailing bytes ignored
    run_file(4, 0, 2, 0, 65535, 24, 0, 5);
    run_file(0, 0, 2, 65535, 0, 32, 0, 0);
    // Early end of file at each stage
    run_file(0, 0, 2, 2, 2, 24, 1, 0);
    run_file(0, 0, 2, 2, 2, 24, 7, 0);
    run_file(0, 0, 2, 1, 1, 16, 18, 0);
    run_file(0, 0, 1, 1, 1, 24, 18, 0);
    run_file(10, 0, 2, 1, 1, 24, 22, 0);
    run_file(0, 0, 2, 2, 1, 24, 20, 0);
    run_file(0, 0, 2, 2, 1, 24, 21, 0);
    run_file(255, 0, 2, 65535, 65535, 32, 300, 0);
    // Trailing bytes after the last pixel
    run_file(0, 0, 2, 1, 2, 15, 0, 4);
    drain();

    // Random files, mostly well-formed
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > HOLD_OFF_AT) hold_off_req = 1'b1;
      sel = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       depth = 15;
        1:       depth = 16;
        2:       depth = 24;
        default: depth = 32;
      endcase
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      idl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      total = 18 + idl + w * h * (depth / 8);
      if (sel < 7) begin
        run_file(idl, 0, 2, w, h, depth, 0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (sel == 7) begin
        run_file(idl, 0, 2, w, h, depth, $urandom_range(1, total), 0);
      end else if (sel == 8) begin
        run_file(idl, 0, 2, $urandom_range(0, 1) * w, $urandom_range(0, 1) * h, depth, 0,
                 $urandom_range(0, 3));
      end else begin
        // Noisy header: any map, type or depth, sometimes cut short
        run_file($urandom_range(0, 20),
                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 0,
                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 2,
                 $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 40),
                 ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : 0,
                 $urandom_range(0, 2));
      end
      if ($urandom_range(0, 7) == 0 && (!hold_off_req || hold_off_done)) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
